// ===== sv/chse_pkg.sv =====
// Shared types, codes and fixed widths of the cubic Hermite spline evaluator.
package chse_pkg;

    localparam int DATA_W  = 32;
    localparam int CNT_W   = 7;
    localparam int OP_W    = 2;
    localparam int IDX_W   = 6;
    localparam int STAT_W  = 2;
    localparam int PADDR_W = 3;

    localparam logic [OP_W-1:0] OP_WRITE     = 2'd0;
    localparam logic [OP_W-1:0] OP_EVAL_CUM  = 2'd1;
    localparam logic [OP_W-1:0] OP_EVAL_NORM = 2'd2;

    localparam logic [STAT_W-1:0] STAT_INTERP     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FIRST      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_LAST       = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NO_POINTS  = 2'd3;

    localparam logic REG_POINT_COUNT = 1'b0;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
    } t_point;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_CLASS,
        S_CLAMP,
        S_RD0,
        S_RD1,
        S_HCOEF,
        S_MUL,
        S_SUM,
        S_FIN,
        S_EMIT
    } t_state;

endpackage

// ===== sv/chse_in_if.sv =====
// Input channel: one command word (write point or evaluate).
interface chse_in_if import chse_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic [IDX_W-1:0]         point_index;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] param_t;

    modport source (output valid, opcode, point_index, pos_x, pos_y, vel_x, vel_y, param_t,
                    input ready);
    modport sink   (input valid, opcode, point_index, pos_x, pos_y, vel_x, vel_y, param_t,
                    output ready);
endinterface

// ===== sv/chse_out_if.sv =====
// Output channel: one evaluated curve point word.
interface chse_out_if import chse_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] curve_x;
    logic signed [DATA_W-1:0] curve_y;
    logic [STAT_W-1:0]        eval_status;

    modport source (output valid, curve_x, curve_y, eval_status, input ready);
    modport sink   (input valid, curve_x, curve_y, eval_status, output ready);
endinterface

// ===== sv/cubic_hermite_spline_eval_core.sv =====
// Cubic Hermite spline evaluator: point table in one synchronous RAM plus an eval sequencer.
// A write word is stored on accept and leaves the input open. An evaluate word is scaled and
// classified; when interpolating, two RAM reads follow, then square, cube, coefficient,
// multiply, sum and round steps; a clamp step at an end point; none with no points.
// The input reopens once the result is loaded, which waits while a previous result is stalled.
// Reset (synchronous, active low) clears point_count, sequencer and output valid, not the table.
module cubic_hermite_spline_eval_core import chse_pkg::*; #(
    parameter int MAX_POINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    chse_in_if.sink            i_item,
    chse_out_if.source         o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int F  = FRAC_BITS;
    localparam int HW = F + 4;
    localparam int PW = HW + DATA_W;
    localparam int SW = PW + 2;
    localparam int TW = DATA_W + CNT_W + 1;
    localparam logic signed [SW-1:0] SAT_MAX = SW'(2147483647);
    localparam logic signed [SW-1:0] SAT_MIN = -SAT_MAX - SW'(1);

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_point_count;
    logic [CNT_W-1:0] n_eff;

    logic [OP_W-1:0]          r_op;
    logic signed [DATA_W-1:0] r_t;
    logic signed [TW-1:0]     r_teff;
    logic [AW-1:0]            r_k;
    logic [F-1:0]             r_s, r_s2, r_s3;
    t_point                   r_p0, r_p1;
    logic signed [HW-1:0]     r_h00, r_h10, r_h01, r_h11;
    logic signed [PW-1:0]     r_mx0, r_mx1, r_mx2, r_mx3;
    logic signed [PW-1:0]     r_my0, r_my1, r_my2, r_my3;
    logic signed [SW-1:0]     r_accx, r_accy;
    logic signed [DATA_W-1:0] r_res_x, r_res_y;
    logic [STAT_W-1:0]        r_res_stat;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_x, r_out_y;
    logic [STAT_W-1:0]        r_out_stat;

    t_point r_mem [MAX_POINTS];
    t_point r_rd_data;
    t_point wr_point;
    logic   wr_en;
    logic [31:0]   idx32;
    logic [AW-1:0] rd_addr;

    logic in_acc, emit_load, cfg_wr;

    logic signed [TW-1:0] seg, last_seg;
    logic [31:0]          n_last32;
    logic                 is_none, is_first, is_last;
    logic [AW-1:0]        class_addr;
    logic [2*F-1:0]       sq, cube;
    logic signed [HW-1:0] s_e, s2_e, s3_e, one_e;
    logic signed [SW-1:0] rnd_x, rnd_y;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        c = v;
        if (v > SAT_MAX) c = SAT_MAX;
        if (v < SAT_MIN) c = SAT_MIN;
        return c[DATA_W-1:0];
    endfunction

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_POINT_COUNT);
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_POINT_COUNT) prdata = {{(32-CNT_W){1'b0}}, r_point_count};
    end

    assign n_eff = ({{(32-CNT_W){1'b0}}, r_point_count} > 32'(MAX_POINTS)) ?
                   CNT_W'(MAX_POINTS) : r_point_count;

    assign in_acc = i_item.valid && i_item.ready;
    assign idx32  = {{(32-IDX_W){1'b0}}, i_item.point_index};
    assign wr_en  = in_acc && (i_item.opcode == OP_WRITE) && (idx32 < 32'(MAX_POINTS));
    assign wr_point = '{pos_x: i_item.pos_x, pos_y: i_item.pos_y,
                        vel_x: i_item.vel_x, vel_y: i_item.vel_y};

    // Segment classification on the scaled parameter.
    assign seg      = r_teff >>> F;
    assign last_seg = TW'({1'b0, n_eff}) - TW'(1);
    assign n_last32 = {{(32-CNT_W){1'b0}}, n_eff} - 32'd1;
    assign is_none  = (n_eff == '0);
    assign is_first = r_teff[TW-1];
    assign is_last  = (seg >= last_seg);
    always_comb begin
        if (is_first)     class_addr = '0;
        else if (is_last) class_addr = n_last32[AW-1:0];
        else              class_addr = seg[AW-1:0];
    end

    assign sq    = {{F{1'b0}}, r_s} * {{F{1'b0}}, r_s};
    assign cube  = {{F{1'b0}}, r_s2} * {{F{1'b0}}, r_s};
    assign s_e   = $signed({4'b0, r_s});
    assign s2_e  = $signed({4'b0, r_s2});
    assign s3_e  = $signed({4'b0, r_s3});
    assign one_e = HW'(1) <<< F;
    assign rnd_x = (r_accx + (SW'(1) <<< (F - 1))) >>> F;
    assign rnd_y = (r_accy + (SW'(1) <<< (F - 1))) >>> F;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_item.opcode == OP_EVAL_CUM || i_item.opcode == OP_EVAL_NORM))
                    n_state = S_SCALE;
            end
            S_SCALE: n_state = S_CLASS;
            S_CLASS: begin
                if (is_none)                    n_state = S_EMIT;
                else if (is_first || is_last)   n_state = S_CLAMP;
                else                            n_state = S_RD0;
            end
            S_CLAMP: n_state = S_EMIT;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_HCOEF;
            S_HCOEF: n_state = S_MUL;
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_FIN;
            S_FIN:   n_state = S_EMIT;
            S_EMIT: begin
                if (emit_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        rd_addr   = '0;
        emit_load = 1'b0;
        case (r_state)
            S_CLASS: rd_addr = class_addr;
            S_RD0:   rd_addr = r_k + AW'(1);
            S_EMIT:  emit_load = !r_out_valid || o_result.ready;
            default: rd_addr = '0;
        endcase
    end

    assign i_item.ready = (r_state == S_IDLE) && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_point_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) r_point_count <= pwdata[CNT_W-1:0];
            if (emit_load)            r_out_valid <= 1'b1;
            else if (o_result.ready)  r_out_valid <= 1'b0;
        end
    end

    // Point table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[idx32[AW-1:0]] <= wr_point;
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op <= i_item.opcode;
            r_t  <= i_item.param_t;
        end
        case (r_state)
            S_SCALE: begin
                if (r_op == OP_EVAL_NORM)
                    r_teff <= TW'(r_t) * TW'($signed({1'b0, n_eff - CNT_W'(1)}));
                else
                    r_teff <= TW'(r_t);
            end
            S_CLASS: begin
                r_k <= seg[AW-1:0];
                r_s <= r_teff[F-1:0];
                if (is_none) begin
                    r_res_x    <= '0;
                    r_res_y    <= '0;
                    r_res_stat <= STAT_NO_POINTS;
                end else if (is_first) begin
                    r_res_stat <= STAT_FIRST;
                end else if (is_last) begin
                    r_res_stat <= STAT_LAST;
                end else begin
                    r_res_stat <= STAT_INTERP;
                end
            end
            S_CLAMP: begin
                r_res_x <= r_rd_data.pos_x;
                r_res_y <= r_rd_data.pos_y;
            end
            S_RD0: begin
                r_p0 <= r_rd_data;
                r_s2 <= sq[2*F-1:F];
            end
            S_RD1: begin
                r_p1 <= r_rd_data;
                r_s3 <= cube[2*F-1:F];
            end
            S_HCOEF: begin
                r_h00 <= (s3_e <<< 1) - (s2_e <<< 1) - s2_e + one_e;
                r_h10 <= s3_e - (s2_e <<< 1) + s_e;
                r_h01 <= (s2_e <<< 1) + s2_e - (s3_e <<< 1);
                r_h11 <= s3_e - s2_e;
            end
            S_MUL: begin
                r_mx0 <= PW'(r_h00) * PW'($signed(r_p0.pos_x));
                r_mx1 <= PW'(r_h10) * PW'($signed(r_p0.vel_x));
                r_mx2 <= PW'(r_h01) * PW'($signed(r_p1.pos_x));
                r_mx3 <= PW'(r_h11) * PW'($signed(r_p1.vel_x));
                r_my0 <= PW'(r_h00) * PW'($signed(r_p0.pos_y));
                r_my1 <= PW'(r_h10) * PW'($signed(r_p0.vel_y));
                r_my2 <= PW'(r_h01) * PW'($signed(r_p1.pos_y));
                r_my3 <= PW'(r_h11) * PW'($signed(r_p1.vel_y));
            end
            S_SUM: begin
                r_accx <= SW'(r_mx0) + SW'(r_mx1) + SW'(r_mx2) + SW'(r_mx3);
                r_accy <= SW'(r_my0) + SW'(r_my1) + SW'(r_my2) + SW'(r_my3);
            end
            S_FIN: begin
                r_res_x <= sat32(rnd_x);
                r_res_y <= sat32(rnd_y);
            end
            default: begin
            end
        endcase
        if (emit_load) begin
            r_out_x    <= r_res_x;
            r_out_y    <= r_res_y;
            r_out_stat <= r_res_stat;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.curve_x     = r_out_x;
    assign o_result.curve_y     = r_out_y;
    assign o_result.eval_status = r_out_stat;

endmodule

// ===== sv/chse_checker.sv =====
// Port-level assertions for the spline evaluator and their bind to the top level.
module chse_checker import chse_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic [OP_W-1:0]          i_in_opcode,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic signed [DATA_W-1:0] i_out_x,
    input logic signed [DATA_W-1:0] i_out_y,
    input logic [STAT_W-1:0]        i_out_stat
);

    // A stalled result word holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
        i_out_valid && $stable(i_out_x) && $stable(i_out_y) && $stable(i_out_stat))
        else $error("result word changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_no_points_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_stat == STAT_NO_POINTS) |-> (i_out_x == '0) && (i_out_y == '0))
        else $error("empty table result is not the origin");

    // An evaluation occupies the sequencer, so the input must close right after it.
    a_eval_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready &&
        (i_in_opcode == OP_EVAL_CUM || i_in_opcode == OP_EVAL_NORM) |=> !i_in_ready)
        else $error("input still open after an evaluate word");

endmodule

bind cubic_hermite_spline_eval_core chse_checker u_chse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_opcode (i_item.opcode),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_x     (o_result.curve_x),
    .i_out_y     (o_result.curve_y),
    .i_out_stat  (o_result.eval_status)
);

// ===== tb/tb_cubic_hermite_spline_eval_core.sv =====
// Self-checking testbench for the cubic Hermite spline evaluator core.
`timescale 1ns / 1ps

module tb_cubic_hermite_spline_eval_core import chse_pkg::*; ();

    localparam int     MAX_PTS       = 64;
    localparam int     FRAC          = 16;
    localparam longint ONE_FX        = 64'sd1 << FRAC;
    localparam longint SAT_MAX       = 64'sd2147483647;
    localparam longint SAT_MIN       = -64'sd2147483648;
    localparam int     SETTLE_CYCLES = 20;
    localparam int     DRAIN_LIMIT   = 5000;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     PHASE_ITEMS   = 150;

    localparam logic [OP_W-1:0]    OP_UNUSED        = 2'd3;
    localparam logic [PADDR_W-1:0] ADDR_POINT_COUNT = {REG_POINT_COUNT, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED    = {~REG_POINT_COUNT, 2'b00};

    typedef struct {
        logic [OP_W-1:0]          op;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] vx;
        logic signed [DATA_W-1:0] vy;
        logic signed [DATA_W-1:0] t;
    } t_cmd_word;

    typedef struct {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic [STAT_W-1:0]        status;
    } t_curve_point;

    logic clk = 1'b0;
    logic rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    chse_in_if  item_ch ();
    chse_out_if result_ch ();

    // Shadow copy of the point table and the count register.
    logic signed [DATA_W-1:0] pos_x_tab [MAX_PTS];
    logic signed [DATA_W-1:0] pos_y_tab [MAX_PTS];
    logic signed [DATA_W-1:0] vel_x_tab [MAX_PTS];
    logic signed [DATA_W-1:0] vel_y_tab [MAX_PTS];
    bit                       entry_written [MAX_PTS];
    logic [CNT_W-1:0]         count_reg;

    t_curve_point expected_points [$];
    int           fail_count = 0;
    int           burst_left = 0;
    logic         hold_off = 1'b0;
    event         hold_go;

    cubic_hermite_spline_eval_core u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // One axis of the Hermite blend, weighted sum rounded half up and saturated.
    function automatic logic signed [DATA_W-1:0] blend_axis(input longint p0, input longint v0,
                                                            input longint p1, input longint v1,
                                                            input longint s);
        longint s2, s3, h00, h10, h01, h11, acc, r;
        s2  = (s * s) >>> FRAC;
        s3  = (s2 * s) >>> FRAC;
        h00 = 2 * s3 - 3 * s2 + ONE_FX;
        h10 = s3 - 2 * s2 + s;
        h01 = 3 * s2 - 2 * s3;
        h11 = s3 - s2;
        acc = h00 * p0 + h10 * v0 + h01 * p1 + h11 * v1;
        r   = (acc + (ONE_FX >>> 1)) >>> FRAC;
        if (r > SAT_MAX) begin
            r = SAT_MAX;
        end else if (r < SAT_MIN) begin
            r = SAT_MIN;
        end
        return r[31:0];
    endfunction

    function automatic int points_in_use();
        return (count_reg > MAX_PTS) ? MAX_PTS : int'(count_reg);
    endfunction

    function automatic t_curve_point predict_curve(input logic [OP_W-1:0] op,
                                                   input logic signed [DATA_W-1:0] t_in);
        t_curve_point r;
        longint n, t, seg;
        int k;
        n = points_in_use();
        r.x = '0;
        r.y = '0;
        if (n == 0) begin
            r.status = STAT_NO_POINTS;
            return r;
        end
        t = t_in;
        if (op == OP_EVAL_NORM) t = t * (n - 1);
        if (t < 0) begin
            r.x = pos_x_tab[0];
            r.y = pos_y_tab[0];
            r.status = STAT_FIRST;
            return r;
        end
        seg = t >>> FRAC;
        if (seg >= n - 1) begin
            r.x = pos_x_tab[n - 1];
            r.y = pos_y_tab[n - 1];
            r.status = STAT_LAST;
            return r;
        end
        k = int'(seg);
        r.x = blend_axis(pos_x_tab[k], vel_x_tab[k], pos_x_tab[k + 1], vel_x_tab[k + 1],
                         t & (ONE_FX - 1));
        r.y = blend_axis(pos_y_tab[k], vel_y_tab[k], pos_y_tab[k + 1], vel_y_tab[k + 1],
                         t & (ONE_FX - 1));
        r.status = STAT_INTERP;
        return r;
    endfunction

    function automatic t_cmd_word make_word(input logic [OP_W-1:0] op,
                                            input int idx,
                                            input logic [31:0] px, input logic [31:0] py,
                                            input logic [31:0] vx, input logic [31:0] vy,
                                            input logic [31:0] t);
        t_cmd_word c;
        c.op = op; c.idx = IDX_W'(idx);
        c.px = px; c.py = py; c.vx = vx; c.vy = vy;
        c.t  = t;
        return c;
    endfunction

    // Lowest entry among those in use that was never written, or -1.
    function automatic int lowest_unwritten(input int n);
        for (int i = 0; i < n; i++) begin
            if (!entry_written[i]) return i;
        end
        return -1;
    endfunction

    function automatic logic [31:0] random_coord();
        if ($urandom_range(0, 2) == 0) return $urandom;
        return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
    endfunction

    function automatic t_cmd_word random_word();
        t_cmd_word c;
        int n, pick, hole, sel;
        n    = points_in_use();
        hole = lowest_unwritten(n);
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 9);
        c = make_word(OP_UNUSED, $urandom, random_coord(), random_coord(), random_coord(),
                      random_coord(), $urandom);
        if (hole >= 0) begin
            // Fill the table before any evaluation may read it.
            c.op  = OP_WRITE;
            c.idx = IDX_W'(hole);
        end else if (pick < 22) begin
            c.op = OP_WRITE;
            if (n > 0 && pick < 17) c.idx = IDX_W'($urandom_range(0, n - 1));
        end else if (pick < 26) begin
            c.op = OP_UNUSED;
        end else begin
            c.op = (pick < 63) ? OP_EVAL_CUM : OP_EVAL_NORM;
            if (n >= 1 && sel != 0) begin
                if (sel == 1) begin
                    c.t = -int'($urandom_range(1, 24'hFF_FFFF));
                end else if (sel == 2 || n == 1) begin
                    c.t = (c.op == OP_EVAL_CUM) ? (n - 1) * 65536 + $urandom_range(0, 1 << 20)
                                                : 65536 + $urandom_range(0, 1 << 18);
                end else begin
                    c.t = (c.op == OP_EVAL_CUM) ? $urandom_range(0, (n - 1) * 65536 - 1)
                                                : $urandom_range(0, 65535);
                end
            end
        end
        return c;
    endfunction

    // Offers one word, with an occasional gap between bursts, and records its effect.
    task automatic send_word(input t_cmd_word c);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        item_ch.opcode      <= c.op;
        item_ch.point_index <= c.idx;
        item_ch.pos_x       <= c.px;
        item_ch.pos_y       <= c.py;
        item_ch.vel_x       <= c.vx;
        item_ch.vel_y       <= c.vy;
        item_ch.param_t     <= c.t;
        item_ch.valid       <= 1'b1;
        do @(posedge clk); while (!item_ch.ready);
        if (c.op == OP_WRITE) begin
            pos_x_tab[c.idx]     = c.px;
            pos_y_tab[c.idx]     = c.py;
            vel_x_tab[c.idx]     = c.vx;
            vel_y_tab[c.idx]     = c.vy;
            entry_written[c.idx] = 1'b1;
        end else if (c.op == OP_EVAL_CUM || c.op == OP_EVAL_NORM) begin
            expected_points.insert(expected_points.size(), predict_curve(c.op, c.t));
        end
    endtask

    // Stops offering words, waits for every pending result and lets the sequencer settle.
    task automatic wait_idle();
        int guard;
        guard = 0;
        @(negedge clk);
        item_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_points.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        if (expected_points.size() != 0) begin
            report_mismatch("results still pending", expected_points.size(), 0);
            expected_points.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic check_point_count();
        logic [31:0] got;
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= ADDR_POINT_COUNT;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0;
        if (got !== {{(32 - CNT_W){1'b0}}, count_reg}) begin
            report_mismatch("point_count readback", got, {{(32 - CNT_W){1'b0}}, count_reg});
        end
    endtask

    task automatic set_point_count(input int value);
        wait_idle();
        apb_write(ADDR_POINT_COUNT, value);
        count_reg = value[CNT_W-1:0];
        check_point_count();
    endtask

    task automatic test_empty_table();
        check_point_count();
        // A write to an address with no register must leave the count alone.
        apb_write(ADDR_UNMAPPED, 32'h0000_0005);
        check_point_count();
        send_word(make_word(OP_EVAL_CUM, 0, 0, 0, 0, 0, 32'h0000_0000));
        send_word(make_word(OP_EVAL_NORM, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    endtask

    task automatic test_single_point();
        send_word(make_word(OP_WRITE, 0, 32'h0001_8000, 32'hFFFE_0000, 32'h0000_1000,
                            32'h7FFF_FFFF, 0));
        set_point_count(1);
        send_word(make_word(OP_EVAL_CUM, 0, 0, 0, 0, 0, 32'h0000_0000));
        send_word(make_word(OP_EVAL_NORM, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
        send_word(make_word(OP_EVAL_CUM, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    endtask

    task automatic test_segment_edges();
        send_word(make_word(OP_WRITE, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h8000_0000, 0));
        send_word(make_word(OP_WRITE, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 0));
        send_word(make_word(OP_WRITE, 2, 32'h0000_0000, 32'h0001_0000, 32'hFFFF_FFFF,
                            32'h0000_0001, 0));
        send_word(make_word(OP_WRITE, 63, 32'h5555_AAAA, 32'hAAAA_5555, 32'h0F0F_F0F0,
                            32'hF0F0_0F0F, 0));
        set_point_count(3);
        send_word(make_word(OP_EVAL_CUM, 0, 0, 0, 0, 0, 32'h0000_0000));
        send_word(make_word(OP_EVAL_CUM, 0, 0, 0, 0, 0, 32'h0000_FFFF));
        // Mid segment with both ends at full scale overshoots and saturates.
        send_word(make_word(OP_EVAL_CUM, 0, 0, 0, 0, 0, 32'h0000_8000));
        send_word(make_word(OP_EVAL_CUM, 0, 0, 0, 0, 0, 32'h0001_8000));
        send_word(make_word(OP_EVAL_CUM, 0, 0, 0, 0, 0, 32'h0001_FFFF));
        send_word(make_word(OP_EVAL_CUM, 0, 0, 0, 0, 0, 32'h0002_0000));
        send_word(make_word(OP_EVAL_CUM, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
        send_word(make_word(OP_EVAL_CUM, 0, 0, 0, 0, 0, 32'h8000_0000));
        send_word(make_word(OP_UNUSED, 5, 32'hFFFF_FFFF, 0, 0, 0, 32'h0000_8000));
        send_word(make_word(OP_EVAL_NORM, 0, 0, 0, 0, 0, 32'h0000_8000));
        send_word(make_word(OP_EVAL_NORM, 0, 0, 0, 0, 0, 32'h0000_FFFF));
        send_word(make_word(OP_EVAL_NORM, 0, 0, 0, 0, 0, 32'h0001_0000));
        send_word(make_word(OP_EVAL_NORM, 0, 0, 0, 0, 0, 32'h8000_0000));
    endtask

    task automatic test_random_phases();
        int phase_counts [11];
        phase_counts = '{2, 5, 64, 127, 1, 17, 0, 33, 3, 64, 9};
        phase_counts[10] = $urandom_range(0, 127);
        foreach (phase_counts[p]) begin
            set_point_count(phase_counts[p]);
            repeat (PHASE_ITEMS) send_word(random_word());
        end
    endtask

    // The receiver holds off long enough that the block backs up into its input.
    task automatic test_output_backpressure();
        set_point_count(8);
        while (lowest_unwritten(8) >= 0) send_word(random_word());
        ->hold_go;
        repeat (48) send_word(random_word());
    endtask

    initial begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        item_ch.valid = 1'b0; item_ch.opcode = OP_WRITE; item_ch.point_index = '0;
        item_ch.pos_x = '0; item_ch.pos_y = '0; item_ch.vel_x = '0; item_ch.vel_y = '0;
        item_ch.param_t = '0;
        count_reg = '0;
        foreach (entry_written[i]) entry_written[i] = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_empty_table();
        test_single_point();
        test_segment_edges();
        test_random_phases();
        test_output_backpressure();
        wait_idle();

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Receiver: switches between stall patterns, and goes quiet during a hold-off.
    initial begin
        int mode, mode_left, run, tick;
        result_ch.ready = 1'b0;
        mode = 0; mode_left = 0; run = 0; tick = 0;
        forever begin
            @(negedge clk);
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(40, 400);
            end
            mode_left--;
            tick++;
            if (hold_off) begin
                result_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= ($urandom_range(0, 9) < 6);
                    2: result_ch.ready <= ((tick % 7) >= 3);
                    default: begin
                        if (run == 0 && $urandom_range(0, 15) == 0) run = $urandom_range(1, 12);
                        if (run > 0) run--;
                        result_ch.ready <= (run == 0);
                    end
                endcase
            end
        end
    end

    initial begin
        forever begin
            @(hold_go);
            @(posedge clk);
            hold_off = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off = 1'b0;
        end
    end

    always @(posedge clk) begin
        t_curve_point want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected word", result_ch.curve_x, 0);
            end else begin
                want = expected_points.pop_front();
                if (result_ch.curve_x !== want.x) begin
                    report_mismatch("curve_x", result_ch.curve_x, want.x);
                end
                if (result_ch.curve_y !== want.y) begin
                    report_mismatch("curve_y", result_ch.curve_y, want.y);
                end
                if (result_ch.eval_status !== want.status) begin
                    report_mismatch("eval_status", 32'(result_ch.eval_status),
                                    32'(want.status));
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/chse_pkg.sv
sv/chse_in_if.sv
sv/chse_out_if.sv
sv/cubic_hermite_spline_eval_core.sv
sv/chse_checker.sv
tb/tb_cubic_hermite_spline_eval_core.sv
